// ----- sv/crt_pkg.sv -----
package crt_pkg;

    localparam int ROUTE_ENTRIES_DEF   = 16;
    localparam int BCAST_ENTRIES_DEF   = 8;
    localparam int LEARNED_ENTRIES_DEF = 32;

    localparam int CALL_W = 56;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;
    localparam int FLAG_W = 4;

    localparam logic [CALL_W-1:0] NORM_KEEP = 56'hfefefefefefe1e;
    localparam logic [CALL_W-1:0] NORM_SET  = 56'h00000000000060;

    localparam logic [1:0] OP_ADD_ROUTE = 2'd0;
    localparam logic [1:0] OP_ADD_BCAST = 2'd1;
    localparam logic [1:0] OP_HEARD     = 2'd2;
    localparam logic [1:0] OP_LOOKUP    = 2'd3;

    localparam logic [1:0] KIND_ROUTE   = 2'd0;
    localparam logic [1:0] KIND_LEARNED = 2'd1;
    localparam logic [1:0] KIND_DEFAULT = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam int FLG_DEFAULT = 0;
    localparam int FLG_BCAST   = 1;
    localparam int FLG_LEARN   = 2;
    localparam int FLG_PERM    = 3;

    typedef struct packed {
        logic [1:0]        op;
        logic [CALL_W-1:0] callsign;
        logic [IP_W-1:0]   ip_addr;
        logic [PORT_W-1:0] gw_port;
        logic              flag_default;
        logic              flag_bcast;
        logic              flag_learn;
        logic              flag_permanent;
    } crt_in_t;

    typedef struct packed {
        logic              found;
        logic [IP_W-1:0]   dest_ip;
        logic [PORT_W-1:0] dest_port;
        logic [1:0]        source_kind;
        logic              dns_check;
        logic              table_full;
    } crt_out_t;

    typedef struct packed {
        logic [CALL_W-1:0] call;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [FLAG_W-1:0] flags;
    } route_ent_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RT_RD,
        ST_RT_CMP,
        ST_BC_RD,
        ST_BC_CMP,
        ST_IP_RD,
        ST_IP_CMP,
        ST_LN_RD,
        ST_LN_CMP,
        ST_FE_RD,
        ST_FE_CMP
    } crt_state_t;

    function automatic logic [CALL_W-1:0] normalize(input logic [CALL_W-1:0] c);
        return (c & NORM_KEEP) | NORM_SET;
    endfunction

endpackage

// ----- sv/crt_ram.sv -----
module crt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/callsign_route_table_top.sv -----
// Channel  | Ports               | Handshake
// ---------+---------------------+---------------------------------------------
// command  | start, busy, cmd    | beat taken on a rising edge with start & !busy
// result   | done, result        | one beat per command, done high one cycle
//
// Add route and add broadcast finish in the idle state and never raise busy.
// Heard and lookup walk the tables one entry at a time, a read state then a
// compare state per entry, through one shared callsign comparator.
// Reset clears the fill counts and the default pointer; table contents need no
// clearing since only entries below a fill count are read. The receiver cannot
// stall: done marks a result for exactly one cycle after the command ends.
module callsign_route_table_top #(
    parameter int ROUTE_ENTRIES   = crt_pkg::ROUTE_ENTRIES_DEF,
    parameter int BCAST_ENTRIES   = crt_pkg::BCAST_ENTRIES_DEF,
    parameter int LEARNED_ENTRIES = crt_pkg::LEARNED_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  crt_pkg::crt_in_t  cmd,
    output logic              busy,
    output logic              done,
    output crt_pkg::crt_out_t result
);

    import crt_pkg::*;

    // address widths of the three tables and widths of their fill counts
    localparam int RAW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int BAW = (BCAST_ENTRIES > 1) ? $clog2(BCAST_ENTRIES) : 1;
    localparam int LAW = (LEARNED_ENTRIES > 1) ? $clog2(LEARNED_ENTRIES) : 1;
    localparam int RCW = $clog2(ROUTE_ENTRIES + 1);
    localparam int BCW = $clog2(BCAST_ENTRIES + 1);
    localparam int LCW = $clog2(LEARNED_ENTRIES + 1);
    localparam int SCW = (RCW > BCW) ? ((RCW > LCW) ? RCW : LCW)
                                     : ((BCW > LCW) ? BCW : LCW);
    localparam int RW  = $bits(route_ent_t);
    localparam int LW  = CALL_W + RAW;

    crt_state_t        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [CALL_W-1:0] call_reg, call_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic [SCW-1:0]    idx_reg, idx_next;
    logic [RAW-1:0]    hit_idx_reg, hit_idx_next;
    logic [1:0]        kind_reg, kind_next;
    logic              routed_reg, routed_next;
    logic              dns_reg, dns_next;
    logic [RCW-1:0]    route_cnt_reg, route_cnt_next;
    logic [BCW-1:0]    bcast_cnt_reg, bcast_cnt_next;
    logic [LCW-1:0]    learn_cnt_reg, learn_cnt_next;
    logic              def_valid_reg, def_valid_next;
    logic [RAW-1:0]    def_idx_reg, def_idx_next;
    logic              done_reg, done_next;
    crt_out_t          res_reg, res_next;

    // table ports
    logic              rt_we;
    logic [RAW-1:0]    rt_waddr, rt_raddr;
    route_ent_t        rt_wdata, rt_q;
    logic [RW-1:0]     rt_q_raw;
    logic              bc_we;
    logic [BAW-1:0]    bc_waddr;
    logic [CALL_W-1:0] bc_q;
    logic              ln_we;
    logic [LAW-1:0]    ln_waddr;
    logic [LW-1:0]     ln_wdata, ln_q;
    logic [CALL_W-1:0] ln_q_call;
    logic [RAW-1:0]    ln_q_route;

    // shared callsign comparator
    logic [CALL_W-1:0] key_q;
    logic              key_hit;
    logic [CALL_W-1:0] cmd_call;

    assign cmd_call   = normalize(cmd.callsign);
    assign rt_q       = route_ent_t'(rt_q_raw);
    assign ln_q_call  = ln_q[LW-1:RAW];
    assign ln_q_route = ln_q[RAW-1:0];

    always_comb
    begin
        unique case (state_reg)
            ST_BC_RD, ST_BC_CMP: key_q = bc_q;
            ST_LN_RD, ST_LN_CMP: key_q = ln_q_call;
            default:             key_q = rt_q.call;
        endcase
    end

    assign key_hit = (key_q == call_reg);

    // routes are read at the scan index, or at the chosen route when fetching
    assign rt_raddr = (state_reg == ST_FE_RD || state_reg == ST_FE_CMP)
                      ? hit_idx_reg : idx_reg[RAW-1:0];

    crt_ram #(.WIDTH(RW), .DEPTH(ROUTE_ENTRIES), .AW(RAW)) u_route_ram (
        .clk   (clk),
        .we    (rt_we),
        .waddr (rt_waddr),
        .wdata (rt_wdata),
        .raddr (rt_raddr),
        .rdata (rt_q_raw)
    );

    crt_ram #(.WIDTH(CALL_W), .DEPTH(BCAST_ENTRIES), .AW(BAW)) u_bcast_ram (
        .clk   (clk),
        .we    (bc_we),
        .waddr (bc_waddr),
        .wdata (cmd_call),
        .raddr (idx_reg[BAW-1:0]),
        .rdata (bc_q)
    );

    crt_ram #(.WIDTH(LW), .DEPTH(LEARNED_ENTRIES), .AW(LAW)) u_learn_ram (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr),
        .wdata (ln_wdata),
        .raddr (idx_reg[LAW-1:0]),
        .rdata (ln_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            route_cnt_reg <= '0;
            bcast_cnt_reg <= '0;
            learn_cnt_reg <= '0;
            def_valid_reg <= 1'b0;
            def_idx_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            route_cnt_reg <= route_cnt_next;
            bcast_cnt_reg <= bcast_cnt_next;
            learn_cnt_reg <= learn_cnt_next;
            def_valid_reg <= def_valid_next;
            def_idx_reg   <= def_idx_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        call_reg    <= call_next;
        ip_reg      <= ip_next;
        idx_reg     <= idx_next;
        hit_idx_reg <= hit_idx_next;
        kind_reg    <= kind_next;
        routed_reg  <= routed_next;
        dns_reg     <= dns_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        call_next      = call_reg;
        ip_next        = ip_reg;
        idx_next       = idx_reg;
        hit_idx_next   = hit_idx_reg;
        kind_next      = kind_reg;
        routed_next    = routed_reg;
        dns_next       = dns_reg;
        route_cnt_next = route_cnt_reg;
        bcast_cnt_next = bcast_cnt_reg;
        learn_cnt_next = learn_cnt_reg;
        def_valid_next = def_valid_reg;
        def_idx_next   = def_idx_reg;
        done_next      = 1'b0;
        res_next       = res_reg;

        rt_we    = 1'b0;
        rt_waddr = idx_reg[RAW-1:0];
        rt_wdata = rt_q;
        bc_we    = 1'b0;
        bc_waddr = bcast_cnt_reg[BAW-1:0];
        ln_we    = 1'b0;
        ln_waddr = learn_cnt_reg[LAW-1:0];
        ln_wdata = {call_reg, hit_idx_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next     = cmd.op;
                    call_next   = cmd_call;
                    ip_next     = cmd.ip_addr;
                    idx_next    = '0;
                    routed_next = 1'b0;
                    dns_next    = 1'b0;
                    res_next    = '{found: 1'b0, dest_ip: '0, dest_port: '0,
                                    source_kind: KIND_NONE, dns_check: 1'b0,
                                    table_full: 1'b0};
                    unique case (cmd.op)
                        OP_ADD_ROUTE:
                        begin
                            done_next = 1'b1;
                            if (route_cnt_reg >= RCW'(ROUTE_ENTRIES))
                            begin
                                res_next.table_full = 1'b1;
                            end
                            else
                            begin
                                rt_we    = 1'b1;
                                rt_waddr = route_cnt_reg[RAW-1:0];
                                rt_wdata = '{call: cmd_call, ip: cmd.ip_addr,
                                             port: cmd.gw_port,
                                             flags: {cmd.flag_permanent, cmd.flag_learn,
                                                     cmd.flag_bcast, cmd.flag_default}};
                                if (cmd.flag_default)
                                begin
                                    def_valid_next = 1'b1;
                                    def_idx_next   = route_cnt_reg[RAW-1:0];
                                end
                                route_cnt_next = RCW'(route_cnt_reg + 1'b1);
                            end
                        end
                        OP_ADD_BCAST:
                        begin
                            done_next = 1'b1;
                            if (bcast_cnt_reg >= BCW'(BCAST_ENTRIES))
                            begin
                                res_next.table_full = 1'b1;
                            end
                            else
                            begin
                                bc_we          = 1'b1;
                                bcast_cnt_next = BCW'(bcast_cnt_reg + 1'b1);
                            end
                        end
                        default:
                        begin
                            state_next = ST_RT_RD;
                        end
                    endcase
                end
            end

            // route scan by callsign: refresh on heard, first hit on lookup
            ST_RT_RD:
            begin
                if (idx_reg >= SCW'(route_cnt_reg))
                begin
                    idx_next = '0;
                    if (op_reg == OP_LOOKUP)
                    begin
                        state_next = ST_LN_RD;
                    end
                    else if (routed_reg)
                    begin
                        res_next.dns_check = dns_reg;
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_BC_RD;
                    end
                end
                else
                begin
                    state_next = ST_RT_CMP;
                end
            end

            ST_RT_CMP:
            begin
                idx_next   = SCW'(idx_reg + 1'b1);
                state_next = ST_RT_RD;
                if (key_hit)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        hit_idx_next = idx_reg[RAW-1:0];
                        kind_next    = KIND_ROUTE;
                        state_next   = ST_FE_RD;
                    end
                    else
                    begin
                        routed_next = 1'b1;
                        if (rt_q.ip != ip_reg)
                        begin
                            if (rt_q.flags[FLG_LEARN])
                            begin
                                rt_we       = 1'b1;
                                rt_wdata.ip = ip_reg;
                            end
                            if (!rt_q.flags[FLG_PERM])
                            begin
                                dns_next = 1'b1;
                            end
                        end
                    end
                end
            end

            // drop heard frames from broadcast callsigns
            ST_BC_RD:
            begin
                if (idx_reg >= SCW'(bcast_cnt_reg))
                begin
                    idx_next   = '0;
                    state_next = ST_IP_RD;
                end
                else
                begin
                    state_next = ST_BC_CMP;
                end
            end

            ST_BC_CMP:
            begin
                if (key_hit)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = SCW'(idx_reg + 1'b1);
                    state_next = ST_BC_RD;
                end
            end

            // find the first route whose gateway IP is the frame source
            ST_IP_RD:
            begin
                if (idx_reg >= SCW'(route_cnt_reg))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_IP_CMP;
                end
            end

            ST_IP_CMP:
            begin
                if (rt_q.ip == ip_reg)
                begin
                    hit_idx_next = idx_reg[RAW-1:0];
                    idx_next     = '0;
                    state_next   = ST_LN_RD;
                end
                else
                begin
                    idx_next   = SCW'(idx_reg + 1'b1);
                    state_next = ST_IP_RD;
                end
            end

            // learned scan: update or append on heard, answer on lookup
            ST_LN_RD:
            begin
                if (idx_reg >= SCW'(learn_cnt_reg))
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        if (def_valid_reg)
                        begin
                            hit_idx_next = def_idx_reg;
                            kind_next    = KIND_DEFAULT;
                            state_next   = ST_FE_RD;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                        if (learn_cnt_reg >= LCW'(LEARNED_ENTRIES))
                        begin
                            res_next.table_full = 1'b1;
                        end
                        else
                        begin
                            ln_we          = 1'b1;
                            learn_cnt_next = LCW'(learn_cnt_reg + 1'b1);
                        end
                    end
                end
                else
                begin
                    state_next = ST_LN_CMP;
                end
            end

            ST_LN_CMP:
            begin
                if (key_hit)
                begin
                    if (op_reg == OP_LOOKUP)
                    begin
                        hit_idx_next = ln_q_route;
                        kind_next    = KIND_LEARNED;
                        state_next   = ST_FE_RD;
                    end
                    else
                    begin
                        ln_we      = 1'b1;
                        ln_waddr   = idx_reg[LAW-1:0];
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = SCW'(idx_reg + 1'b1);
                    state_next = ST_LN_RD;
                end
            end

            ST_FE_RD:
            begin
                state_next = ST_FE_CMP;
            end

            ST_FE_CMP:
            begin
                res_next.found       = 1'b1;
                res_next.dest_ip     = rt_q.ip;
                res_next.dest_port   = rt_q.port;
                res_next.source_kind = kind_reg;
                done_next            = 1'b1;
                state_next           = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule
